// File: hdl/csd_pkg.sv
// Shared types and constants for the CUSUM change detector.
// No dependencies; used by every module of the block.
package csd_pkg;

  localparam int SAMPLE_PORT_W = 16;  // sample_value field width
  localparam int INDEX_W       = 32;  // change_index field width
  localparam int OUT_DATA_W    = 40;  // flag + index, padded to whole bytes
  localparam int CFG_IDX_W     = 4;
  localparam int CFG_DATA_W    = 16;
  localparam int SUM_W         = 32;  // stored cumulative sums, Q16.16 unsigned
  localparam int SUM_CALC_W    = 35;  // sum + deviation - drift, signed, no overflow

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DRIFT     = 4'd1;

  // 5.0 in Q8.8, also used when the threshold register holds zero
  localparam logic [CFG_DATA_W-1:0] THRESHOLD_DEFAULT = 16'd1280;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// File: hdl/csd_serial_div.sv
// Bit-serial restoring divider for the running-mean update.
// Unsigned dividend and divisor, one quotient bit per cycle. Uses csd_pkg.
module csd_serial_div #(
  parameter int DW = 25,  // dividend / quotient width
  parameter int CW = 32   // divisor width
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DW-1:0]       dividend,
  input  logic [CW-1:0]       divisor,
  output logic [DW-1:0]       quotient,
  output csd_pkg::div_status_t status
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    dvd_r, dvd_nxt;   // dividend shifts out, quotient shifts in
  logic [CW-1:0]    rem_r, rem_nxt;
  logic [CW-1:0]    dsr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [CW:0]      rem_sh;
  logic [CW:0]      diff;
  logic             fits;

  assign rem_sh = {rem_r, dvd_r[DW-1]};
  assign diff   = rem_sh - {1'b0, dsr_r};
  assign fits   = (rem_sh >= {1'b0, dsr_r});

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[DW-2:0], fits};
      rem_nxt = fits ? diff[CW-1:0] : rem_sh[CW-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dsr_r <= divisor;
    end
  end

  assign quotient    = dvd_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

// File: hdl/cusum_change_detector.sv
// Top level of the two-sided CUSUM change detector.
// Depends on csd_pkg and csd_serial_div.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+---------------------------------------
//  in_     | in  | in_tvalid / in_tready  | in_tdata[15:0]  sample_value (Q8.8)
//  out_    | out | out_tvalid / out_tready| out_tdata[0] change_flag,
//          |     |                        | out_tdata[32:1] change_index, rest 0
//  cfg_    | in  | cfg_valid / cfg_ready  | cfg_index (0 threshold, 1 drift), cfg_data
//
// One item at a time: a transfer on in_ is followed by the START, DIV, MEAN, SUM
// and CHECK states, most of the work in the serial divider (SAMPLE_WIDTH + 9 quotient
// bits), so the input takes a new sample only once the sequencer is back in IDLE.
// The result sits in an output register; the next sample is taken while it waits.
// A stalled out_ holds the block only at its final step until the register frees.
// rst_n is synchronous, active low; cfg_ready is always high.
module cusum_change_detector #(
  parameter int COUNT_WIDTH  = 32,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // sample input; in_tdata[15:0] = sample_value
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [csd_pkg::SAMPLE_PORT_W-1:0] in_tdata,
  // results; out_tdata[0] = change_flag, [32:1] = change_index, [39:33] = 0
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [csd_pkg::OUT_DATA_W-1:0]    out_tdata,
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [csd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [csd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int XW = SAMPLE_WIDTH + 8;  // sample / mean in Q8.16
  localparam int DW = XW + 1;            // delta and deviation
  localparam int SC = csd_pkg::SUM_CALC_W;

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;  // launch divider with |delta|
  localparam logic [2:0] S_DIV   = 3'd2;  // wait for quotient
  localparam logic [2:0] S_MEAN  = 3'd3;  // new mean and deviation
  localparam logic [2:0] S_SUM   = 3'd4;  // raw cumulative sums
  localparam logic [2:0] S_CHECK = 3'd5;  // clip, compare, emit result

  logic [2:0] state_r, state_nxt;

  // configuration
  logic [csd_pkg::CFG_DATA_W-1:0] thr_r, drift_r, thr_eff;

  // detector state
  logic [COUNT_WIDTH-1:0]          count_r;
  logic signed [XW-1:0]            mean_r;
  logic [csd_pkg::SUM_W-1:0]       upper_r, lower_r;

  // per-item working registers
  logic signed [DW-1:0]            delta_r, dev_r;
  logic signed [SC-1:0]            upraw_r, loraw_r;

  // output register
  logic                            out_valid_r;
  logic                            out_flag_r;
  logic [csd_pkg::INDEX_W-1:0]     out_index_r;

  logic in_fire, cfg_fire, can_out;

  // sample extraction: low SAMPLE_WIDTH bits of the field, two's complement
  logic [SAMPLE_WIDTH+csd_pkg::SAMPLE_PORT_W-1:0] raw_ext;
  logic signed [XW-1:0]           x_in;
  logic signed [DW-1:0]           delta_calc;

  // divider hookup
  logic [DW-1:0]                  div_dividend, div_quot;
  csd_pkg::div_status_t           div_st;
  logic                           div_start;

  // mean update
  logic signed [DW:0]             q_s, mean_sum, dev_calc;

  // sums
  logic signed [SC-1:0]           up_ext, lo_ext, dev_ext, drift_ext, thr_ext;
  logic signed [SC-1:0]           upraw_calc, loraw_calc;
  logic                           hit;
  logic [csd_pkg::SUM_W-1:0]      up_clip, lo_clip;

  logic [COUNT_WIDTH+csd_pkg::INDEX_W-1:0] index_ext;
  logic [COUNT_WIDTH-1:0]         index_raw;

  assign in_fire  = in_tvalid && in_tready;
  assign cfg_fire = cfg_valid && cfg_ready;
  assign can_out  = !out_valid_r || out_tready;

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  assign raw_ext    = {{SAMPLE_WIDTH{1'b0}}, in_tdata};
  assign x_in       = {raw_ext[SAMPLE_WIDTH-1:0], 8'h00};
  assign delta_calc = DW'(x_in) - DW'(mean_r);

  // magnitude into the divider; sign kept in delta_r
  assign div_start    = (state_r == S_START);
  assign div_dividend = delta_r[DW-1] ? DW'(-delta_r) : DW'(delta_r);

  csd_serial_div #(
    .DW (DW),
    .CW (COUNT_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (count_r),
    .quotient (div_quot),
    .status   (div_st)
  );

  // quotient truncates toward zero: apply the sign of delta afterwards
  assign q_s      = delta_r[DW-1] ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
  assign mean_sum = (DW+1)'(mean_r) + q_s;
  // deviation from the new mean = delta - quotient
  assign dev_calc = (DW+1)'(delta_r) - q_s;

  assign thr_eff   = (thr_r == '0) ? csd_pkg::THRESHOLD_DEFAULT : thr_r;
  assign up_ext    = SC'({1'b0, upper_r});
  assign lo_ext    = SC'({1'b0, lower_r});
  assign dev_ext   = SC'(dev_r);
  assign drift_ext = SC'({1'b0, drift_r, 8'h00});
  assign thr_ext   = SC'({1'b0, thr_eff, 8'h00});

  assign upraw_calc = up_ext + dev_ext - drift_ext;
  assign loraw_calc = lo_ext - dev_ext - drift_ext;

  // a negative raw sum is below any threshold, so the signed compare suffices
  assign hit     = (upraw_r > thr_ext) || (loraw_r > thr_ext);
  assign up_clip = upraw_r[SC-1] ? '0 : upraw_r[csd_pkg::SUM_W-1:0];
  assign lo_clip = loraw_r[SC-1] ? '0 : loraw_r[csd_pkg::SUM_W-1:0];

  assign index_raw = count_r - COUNT_WIDTH'(1);
  assign index_ext = {{csd_pkg::INDEX_W{1'b0}}, index_raw};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_START;
      S_START: state_nxt = S_DIV;
      S_DIV:   if (div_st.done) state_nxt = S_MEAN;
      S_MEAN:  state_nxt = S_SUM;
      S_SUM:   state_nxt = S_CHECK;
      S_CHECK: if (can_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and detector state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      thr_r       <= csd_pkg::THRESHOLD_DEFAULT;
      drift_r     <= '0;
      count_r     <= '0;
      mean_r      <= '0;
      upper_r     <= '0;
      lower_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_fire) begin
        case (cfg_index)
          csd_pkg::REG_THRESHOLD: thr_r   <= cfg_data;
          csd_pkg::REG_DRIFT:     drift_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_fire && !(&count_r)) begin
        count_r <= count_r + COUNT_WIDTH'(1);
      end
      if (state_r == S_MEAN) begin
        mean_r <= mean_sum[XW-1:0];
      end
      if (state_r == S_CHECK && can_out) begin
        upper_r     <= hit ? '0 : up_clip;
        lower_r     <= hit ? '0 : lo_clip;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      delta_r <= delta_calc;
    end
    if (state_r == S_MEAN) begin
      dev_r <= dev_calc[DW-1:0];
    end
    if (state_r == S_SUM) begin
      upraw_r <= upraw_calc;
      loraw_r <= loraw_calc;
    end
    if (state_r == S_CHECK && can_out) begin
      out_flag_r  <= hit;
      out_index_r <= index_ext[csd_pkg::INDEX_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_index_r, out_flag_r};

endmodule

// File: hdl/csd_checker.sv
// Port-level checks for the CUSUM change detector, bound to the top level.
// Depends on csd_pkg for port widths.
module csd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [csd_pkg::OUT_DATA_W-1:0] out_tdata
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result payload changed while stalled");

  // one sample at a time: busy right after a transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in work");

  // a new result appears only as the block returns to idle
  a_result_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> in_tready)
    else $error("result raised while still busy");

endmodule

bind cusum_change_detector csd_checker u_csd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: test/cusum_change_detector_tb.sv
// Self-checking testbench for cusum_change_detector: streams Q8.8 samples, predicts
// each change flag and sample index in-line, and compares every output transfer.
// Depends on csd_pkg and the detector RTL; needs no files or arguments.
`timescale 1ns / 100ps

module cusum_change_detector_tb;

  // Sample counter at the block's default width.
  localparam int     CNT_W          = 32;
  localparam longint CNT_MAX        = (longint'(1) << CNT_W) - 1;
  localparam int     RAND_PHASES    = 10;
  localparam int     PHASE_SAMPLES  = 105;   // ~1050 random samples in all
  localparam int     DRAIN_CYCLES   = 50;    // quiet tail, longer than one item's latency
  localparam int     WATCHDOG_LIMIT = 2000;  // idle cycles allowed before the watchdog fails the run
  localparam int     REPORT_MAX     = 10;

  // first index past the defined registers; writes there must be ignored
  localparam logic [csd_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LO =
    csd_pkg::CFG_IDX_W'(csd_pkg::REG_DRIFT + 1);
  localparam logic [csd_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HI = '1;

  // directed samples: full-scale swings, +/-1 LSB, small and large steps
  localparam logic [csd_pkg::SAMPLE_PORT_W-1:0] DIRECTED_A [12] = '{
    16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h0001,
    16'hFFFF, 16'h0000, 16'h0500, 16'h0500, 16'h0500, 16'hFB00
  };
  localparam logic [csd_pkg::SAMPLE_PORT_W-1:0] DIRECTED_B [12] = '{
    16'h0100, 16'h0100, 16'h0100, 16'h0100, 16'h0A00, 16'h0A00,
    16'hF600, 16'hF600, 16'h7FFF, 16'h8000, 16'h5555, 16'hAAAA
  };

  typedef struct {
    logic        change_flag;
    logic [31:0] change_idx;
  } detection_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                              in_tvalid = 1'b0;
  logic                              in_tready;
  logic [csd_pkg::SAMPLE_PORT_W-1:0] in_tdata  = '0;   // [15:0] sample_value
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  // [0] change_flag, [32:1] change_index, rest 0
  logic [csd_pkg::OUT_DATA_W-1:0]    out_tdata;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [csd_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
  logic [csd_pkg::CFG_DATA_W-1:0]    cfg_data  = '0;

  cusum_change_detector #(
    .COUNT_WIDTH (CNT_W),
    .SAMPLE_WIDTH(csd_pkg::SAMPLE_PORT_W)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Detector model state. Registers are only changed while the block is idle,
  // so updating them at the cfg transfer keeps them in step with the RTL.
  // ---------------------------------------------------------------------------
  longint thr_q   = csd_pkg::THRESHOLD_DEFAULT;
  longint drift_q = 0;
  longint cnt_q   = 0;
  longint mean_q  = 0;   // Q16.16 signed
  longint upper_q = 0;   // Q16.16, kept in [0, 2^32-1]
  longint lower_q = 0;

  logic [csd_pkg::SAMPLE_PORT_W-1:0] sample_feed_q [$];   // samples waiting for the driver
  detection_t                        detections_due [$];  // predicted results, oldest first
  int                                mismatches = 0;

  // random sample shaping: piecewise-constant level plus noise
  int seg_left  = 0;
  int seg_level = 0;
  int seg_amp   = 1;

  function automatic longint clip_sum(longint v);
    if (v < 0) return 0;
    if (v > 64'hFFFF_FFFF) return 64'hFFFF_FFFF;
    return v;
  endfunction

  function automatic detection_t cusum_predict(logic [csd_pkg::SAMPLE_PORT_W-1:0] raw);
    detection_t r;
    longint     x;
    longint     dev;
    longint     drift;
    longint     thr;
    x = longint'($signed(raw)) * 256;            // Q8.8 -> Q16.16
    if (cnt_q < CNT_MAX) cnt_q++;                 // saturating count
    mean_q  = mean_q + (x - mean_q) / cnt_q;      // longint '/' truncates toward zero
    dev     = x - mean_q;
    drift   = drift_q * 256;
    upper_q = clip_sum(upper_q + dev - drift);
    lower_q = clip_sum(lower_q - dev - drift);
    // zero threshold falls back to 5.0
    thr = ((thr_q == 0) ? longint'(csd_pkg::THRESHOLD_DEFAULT) : thr_q) * 256;
    r.change_flag = (upper_q > thr) || (lower_q > thr);
    if (r.change_flag) begin
      upper_q = 0;
      lower_q = 0;
    end
    r.change_idx = 32'(cnt_q - 1);
    return r;
  endfunction

  function automatic logic [csd_pkg::SAMPLE_PORT_W-1:0] next_sample();
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      case ($urandom_range(0, 3))
        0:       return 16'h7FFF;
        1:       return 16'h8000;
        2:       return 16'h0000;
        default: return 16'hFFFF;
      endcase
    end
    if (r < 16) return 16'($urandom);          // broadband noise
    if (seg_left == 0) begin
      seg_left  = $urandom_range(4, 80);
      seg_level = $urandom_range(0, 1) ? int'($urandom_range(0, 65535)) - 32768
                                       : int'($urandom_range(0, 4096)) - 2048;
      seg_amp   = 1 << $urandom_range(0, 11);
    end
    seg_left--;
    v = seg_level + int'($urandom_range(0, 2 * seg_amp)) - seg_amp;
    if (v > 32767)  v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  task automatic note_mismatch(string what, longint expv, longint actv);
    if (mismatches < REPORT_MAX)
      $display("%0t: %s mismatch, expected %0d got %0d", $realtime, what, expv, actv);
    mismatches++;
  endtask

  task automatic cfg_write(input logic [csd_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [csd_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      csd_pkg::REG_THRESHOLD: thr_q   = val;
      csd_pkg::REG_DRIFT:     drift_q = val;
      default: ;                                 // unmapped index, no effect
    endcase
  endtask

  // wait until every queued sample went in and every predicted result came out
  task automatic wait_drained();
    do @(negedge clk);
    while (sample_feed_q.size() != 0 || in_tvalid || detections_due.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Sample driver: bursts of random length separated by random gaps. A held
  // sample stays valid until it is taken.
  // ---------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        detections_due.push_back(cusum_predict(in_tdata));
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          gap_left  <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (sample_feed_q.size() != 0) begin
          in_tdata  <= sample_feed_q.pop_front();
          in_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            // occasional long burst gives stretches with no idling at all
            burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 24);
            case ($urandom_range(0, 9))
              0, 1, 2:    gap_left <= 0;
              8, 9:       gap_left <= $urandom_range(13, 60);
              default:    gap_left <= $urandom_range(1, 12);
            endcase
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: rotating ready pattern, reloaded whenever pat_age wraps; a quarter
  // of the patterns never stall. Bit 0 is forced so every pattern holds a ready bit.
  // ---------------------------------------------------------------------------
  logic [31:0] stall_pat = '1;
  logic [7:0]  pat_age   = '0;

  always @(posedge clk) begin : result_mon
    detection_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (detections_due.size() == 0) begin
        note_mismatch("unexpected result, change_index", -1, out_tdata[32:1]);
      end else begin
        want = detections_due.pop_front();
        if (out_tdata[0] !== want.change_flag)
          note_mismatch("change_flag", want.change_flag, out_tdata[0]);
        if (out_tdata[32:1] !== want.change_idx)
          note_mismatch("change_index", want.change_idx, out_tdata[32:1]);
        if (out_tdata[csd_pkg::OUT_DATA_W-1:33] !== '0)
          note_mismatch("tdata padding", 0, out_tdata[csd_pkg::OUT_DATA_W-1:33]);
      end
    end
    pat_age <= pat_age + 1'b1;
    if (pat_age == 8'hFF)
      stall_pat <= ($urandom_range(0, 3) == 0) ? '1 : ($urandom | 32'h1);
    else
      stall_pat <= {stall_pat[30:0], stall_pat[31]};
    out_tready <= stall_pat[0];
  end

  // watchdog: any transfer on any channel restarts the count
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequence. Each phase drains fully before the registers change,
  // which also makes the sender pause until all results are back.
  // ---------------------------------------------------------------------------
  initial begin : stim
    logic [csd_pkg::CFG_DATA_W-1:0] thr_val;
    logic [csd_pkg::CFG_DATA_W-1:0] drift_val;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset register values (threshold 5.0, no drift)
    foreach (DIRECTED_A[i]) sample_feed_q.push_back(DIRECTED_A[i]);
    wait_drained();

    // zero threshold must behave as 5.0; unmapped write must change nothing
    cfg_write(csd_pkg::REG_THRESHOLD, '0);
    cfg_write(csd_pkg::REG_DRIFT, 16'h0080);
    cfg_write(REG_UNMAPPED_LO, 16'($urandom));
    foreach (DIRECTED_B[i]) sample_feed_q.push_back(DIRECTED_B[i]);
    wait_drained();

    // random phases; first three hit the register extremes
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin thr_val = 16'd1;     drift_val = 16'd0;     end
        1: begin thr_val = 16'hFFFF;  drift_val = 16'd0;     end
        2: begin thr_val = 16'd0;     drift_val = 16'hFFFF;  end
        3: begin
          thr_val   = 16'($urandom_range(1, 65535));
          drift_val = 16'($urandom_range(0, 65535));
        end
        default: begin
          thr_val   = 16'($urandom_range(32, 2048));
          drift_val = 16'($urandom_range(0, 64));
        end
      endcase
      cfg_write(csd_pkg::REG_THRESHOLD, thr_val);
      cfg_write(csd_pkg::REG_DRIFT, drift_val);
      if ($urandom_range(0, 2) == 0)
        cfg_write(csd_pkg::CFG_IDX_W'($urandom_range(REG_UNMAPPED_LO, REG_UNMAPPED_HI)),
                  16'($urandom));
      repeat (PHASE_SAMPLES) sample_feed_q.push_back(next_sample());
      wait_drained();
    end

    // quiet tail: nothing further may come out
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (detections_due.size() != 0)
      note_mismatch("results never seen, count", 0, detections_due.size());
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
